[hw/rtl/afl_pkg.sv]
package afl_pkg;

  localparam int DIM_BITS   = 12;
  localparam int PROD_BITS  = 2 * DIM_BITS;
  // one quotient bit per divider stage
  localparam int DIV_STAGES = PROD_BITS;

  typedef logic [DIM_BITS-1:0]  dim_t;
  typedef logic [PROD_BITS-1:0] prod_t;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_FIX_W,
    MODE_FIX_H
  } afl_mode_t;

  typedef struct packed {
    dim_t src_rows;
    dim_t src_cols;
    dim_t box_height;
    dim_t box_width;
    dim_t old_top;
    dim_t old_left;
  } afl_item_t;

  typedef struct packed {
    dim_t fit_top;
    dim_t fit_left;
    dim_t fit_height;
    dim_t fit_width;
    logic size_error;
  } afl_result_t;

  // fields carried alongside the divider pipeline
  typedef struct packed {
    afl_mode_t mode;
    logic      size_error;
    dim_t      box_height;
    dim_t      box_width;
    dim_t      old_top;
    dim_t      old_left;
  } afl_side_t;

endpackage

[hw/rtl/afl_div.sv]
module afl_div import afl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  prod_t     num,
  input  dim_t      den,
  input  afl_side_t side_in,
  output logic      out_valid,
  output prod_t     quot,
  output afl_side_t side_out
);

  // restoring division, one bit per stage; the dividend shifts out of the top
  // of num while quotient bits shift in at the bottom
  dim_t      rem_w  [DIV_STAGES+1];
  prod_t     num_w  [DIV_STAGES+1];
  dim_t      den_w  [DIV_STAGES+1];
  afl_side_t side_w [DIV_STAGES+1];
  logic      v_w    [DIV_STAGES+1];

  assign rem_w[0]  = '0;
  assign num_w[0]  = num;
  assign den_w[0]  = den;
  assign side_w[0] = side_in;
  assign v_w[0]    = in_valid;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [DIM_BITS:0] trial;
    logic [DIM_BITS:0] diff;
    logic              ge;
    dim_t              rem;
    prod_t             nq;
    dim_t              dq;
    afl_side_t         sq;
    logic              vq;

    always_comb begin
      trial = {rem_w[k], num_w[k][PROD_BITS-1]};
      diff  = trial - {1'b0, den_w[k]};
      ge    = (trial >= {1'b0, den_w[k]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vq <= 1'b0;
      end else begin
        vq <= v_w[k];
      end
    end

    always_ff @(posedge clk) begin
      rem <= ge ? diff[DIM_BITS-1:0] : trial[DIM_BITS-1:0];
      nq  <= {num_w[k][PROD_BITS-2:0], ge};
      dq  <= den_w[k];
      sq  <= side_w[k];
    end

    assign rem_w[k+1]  = rem;
    assign num_w[k+1]  = nq;
    assign den_w[k+1]  = dq;
    assign side_w[k+1] = sq;
    assign v_w[k+1]    = vq;
  end

  assign out_valid = v_w[DIV_STAGES];
  assign quot      = num_w[DIV_STAGES];
  assign side_out  = side_w[DIV_STAGES];

endmodule

[hw/rtl/aspect_fit_letterbox.sv]
// Done pulses once start is accepted and the item has passed two setup stages,
// 24 divider stages at one quotient bit each, and one output register.
// Throughput: one transaction per cycle; busy is always low.
// The receiver cannot stall: each result shows for exactly one cycle on done.
// Reset (rst, synchronous) clears all valid bits; transactions in flight are dropped.
module aspect_fit_letterbox import afl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  afl_item_t   item,
  output logic        done,
  output afl_result_t result
);

  // stage 1: zero check and both cross products
  logic      s1_valid;
  afl_item_t s1_item;
  prod_t     s1_prod_ch;
  prod_t     s1_prod_rw;
  logic      s1_err;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    s1_item    <= item;
    s1_prod_ch <= PROD_BITS'(item.src_cols) * PROD_BITS'(item.box_height);
    s1_prod_rw <= PROD_BITS'(item.src_rows) * PROD_BITS'(item.box_width);
    s1_err     <= (item.src_rows == '0) || (item.src_cols == '0) ||
                  (item.box_height == '0) || (item.box_width == '0);
  end

  // stage 2: pick the fixed axis and the division operands
  afl_mode_t mode;
  logic      s2_valid;
  prod_t     s2_num;
  dim_t      s2_den;
  afl_side_t s2_side;

  always_comb begin
    mode = MODE_PASS;
    if (s1_err) begin
      mode = MODE_PASS;
    end else if (s1_item.src_rows > s1_item.box_height) begin
      mode = (s1_item.src_cols > s1_item.box_width && s1_prod_ch >= s1_prod_rw) ?
             MODE_FIX_W : MODE_FIX_H;
    end else if (s1_item.src_rows < s1_item.box_height) begin
      mode = (s1_item.src_cols < s1_item.box_width && s1_prod_rw >= s1_prod_ch) ?
             MODE_FIX_H : MODE_FIX_W;
    end else if (s1_item.src_cols != s1_item.box_width) begin
      mode = (s1_item.src_cols < s1_item.box_width) ? MODE_FIX_H : MODE_FIX_W;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    case (mode)
      MODE_FIX_W: begin
        s2_num <= s1_prod_rw;
        s2_den <= s1_item.src_cols;
      end
      MODE_FIX_H: begin
        s2_num <= s1_prod_ch;
        s2_den <= s1_item.src_rows;
      end
      default: begin
        s2_num <= '0;
        s2_den <= dim_t'(1);
      end
    endcase
    s2_side.mode       <= mode;
    s2_side.size_error <= s1_err;
    s2_side.box_height <= s1_item.box_height;
    s2_side.box_width  <= s1_item.box_width;
    s2_side.old_top    <= s1_item.old_top;
    s2_side.old_left   <= s1_item.old_left;
  end

  logic      dv_valid;
  prod_t     dv_quot;
  afl_side_t dv_side;

  afl_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .num       (s2_num),
    .den       (s2_den),
    .side_in   (s2_side),
    .out_valid (dv_valid),
    .quot      (dv_quot),
    .side_out  (dv_side)
  );

  // output stage: centering margin and final selection
  dim_t        q_lo;
  dim_t        box_sel;
  dim_t        leftover;
  dim_t        margin;
  afl_result_t res_next;

  always_comb begin
    q_lo     = dv_quot[DIM_BITS-1:0];
    box_sel  = (dv_side.mode == MODE_FIX_W) ? dv_side.box_height : dv_side.box_width;
    leftover = box_sel - q_lo;
    // compare against the full quotient, not its low bits
    margin   = (PROD_BITS'(box_sel) >= dv_quot) ? (leftover >> 1) : '0;

    res_next.fit_top    = dv_side.old_top;
    res_next.fit_left   = dv_side.old_left;
    res_next.fit_height = dv_side.box_height;
    res_next.fit_width  = dv_side.box_width;
    res_next.size_error = dv_side.size_error;
    case (dv_side.mode)
      MODE_FIX_W: begin
        res_next.fit_top    = margin;
        res_next.fit_left   = '0;
        res_next.fit_height = q_lo;
      end
      MODE_FIX_H: begin
        res_next.fit_left   = margin;
        res_next.fit_top    = '0;
        res_next.fit_width  = q_lo;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

endmodule
